// File: rtl/tcp_client_connection_fsm_macros.svh
// ----------------------------------------------------------------------------
// TCP client connection engine - assertion macros
// Concurrent assertion wrappers used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef TCP_CLIENT_CONNECTION_FSM_MACROS_SVH
`define TCP_CLIENT_CONNECTION_FSM_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// TCP client connection engine - package
// Widths, codes and structures shared by the engine's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

  // default largest payload per emitted segment
  localparam int MSS_DEFAULT = 1460;

  localparam int SEQ_W   = 32;
  localparam int WIN_W   = 16;
  localparam int LEN_W   = 16;
  localparam int CHUNK_W = 14;
  localparam int CFG_IDX_W = 2;

  // smallest legal TCP header, bytes
  localparam logic [LEN_W-1:0] HDR_BYTES = 16'd20;

  // flag byte bits
  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_RST = 8'h04;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  // action codes
  localparam logic [2:0] ACT_CONNECT = 3'd0;
  localparam logic [2:0] ACT_RETX    = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_SEGMENT = 3'd3;
  localparam logic [2:0] ACT_CLOSE   = 3'd4;

  // status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_PROTO   = 2'd2;
  localparam logic [1:0] STS_RESET   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECV_WINDOW = 2'd1;

  typedef enum logic [2:0] {
    CS_CLOSED      = 3'd0,
    CS_SYN_SENT    = 3'd1,
    CS_ESTABLISHED = 3'd2,
    CS_FIN_WAIT1   = 3'd3,
    CS_FIN_WAIT2   = 3'd4,
    CS_TIME_WAIT   = 3'd5,
    CS_CLOSE_WAIT  = 3'd6,
    CS_LAST_ACK    = 3'd7
  } conn_state_t;

  // sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'b001,
    SEQ_EXEC  = 3'b010,
    SEQ_CHUNK = 3'b100
  } seq_state_t;

  // one accepted input word
  typedef struct packed {
    logic [2:0]       action;
    logic [SEQ_W-1:0] initial_seq;
    logic [LEN_W-1:0] send_length;
    logic [7:0]       seg_flags;
    logic [SEQ_W-1:0] seg_seq;
    logic [SEQ_W-1:0] seg_ack;
    logic [WIN_W-1:0] seg_window;
    logic [3:0]       seg_data_offset;
    logic [LEN_W-1:0] seg_length;
  } item_t;

  // decision for the current item, with the state after it
  typedef struct packed {
    logic             emit;
    logic [7:0]       flags;
    logic [SEQ_W-1:0] seq;
    logic [1:0]       status;
    logic             start_send;
    conn_state_t      state_nxt;
    logic [SEQ_W-1:0] ack_nxt;
    logic [WIN_W-1:0] wnd_nxt;
  } conn_dec_t;

  // live connection registers
  typedef struct packed {
    conn_state_t      state;
    logic [SEQ_W-1:0] snd_nxt;
    logic [SEQ_W-1:0] rcv_nxt;
    logic [WIN_W-1:0] wnd;
  } conn_view_t;

  // current chunk of a send
  typedef struct packed {
    logic               busy;
    logic               last;
    logic [LEN_W-1:0]   off;
    logic [CHUNK_W-1:0] len;
  } chunk_t;

  // one result word
  typedef struct packed {
    logic               has_segment;
    logic [7:0]         flags;
    logic [SEQ_W-1:0]   seq;
    logic [SEQ_W-1:0]   ack;
    logic [WIN_W-1:0]   window;
    logic [LEN_W-1:0]   chunk_offset;
    logic [CHUNK_W-1:0] chunk_length;
    logic [1:0]         status;
    logic [2:0]         conn_state;
    logic [WIN_W-1:0]   peer_window;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tcf_conn.sv
// ----------------------------------------------------------------------------
// TCP client connection engine - connection state
// Holds state, sequence numbers and peer window; decides each item's outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_conn
  import tcf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire item_t              item_i,
  input  wire logic               tx_en,
  input  wire logic               exec_en,
  input  wire logic               chunk_en,
  input  wire logic [CHUNK_W-1:0] chunk_len,
  output conn_dec_t               dec,
  output conn_view_t              view
);

  conn_state_t      state_r, state_nxt;
  logic [SEQ_W-1:0] snd_next_r, snd_next_nxt;
  logic [SEQ_W-1:0] snd_una_r, snd_una_nxt;
  logic [SEQ_W-1:0] rcv_next_r, rcv_next_nxt;
  logic [WIN_W-1:0] snd_wnd_r, snd_wnd_nxt;

  logic [5:0]       hlen;
  logic [LEN_W-1:0] plen;
  logic             malformed;
  logic             f_fin, f_syn, f_rst, f_ack;
  logic             add_plen, add_one;
  logic [LEN_W:0]   rcv_inc;
  logic [SEQ_W-1:0] rcv_sum;
  logic [SEQ_W-1:0] snd_base;
  logic [LEN_W-1:0] snd_inc;
  logic [SEQ_W-1:0] snd_sum;

  // segment header checks
  assign hlen      = {item_i.seg_data_offset, 2'b00};
  assign malformed = (item_i.seg_length < HDR_BYTES) || ({10'b0, hlen} < HDR_BYTES) ||
                     ({10'b0, hlen} > item_i.seg_length);
  assign plen      = item_i.seg_length - {10'b0, hlen};
  assign f_fin     = (item_i.seg_flags & FL_FIN) != 8'h00;
  assign f_syn     = (item_i.seg_flags & FL_SYN) != 8'h00;
  assign f_rst     = (item_i.seg_flags & FL_RST) != 8'h00;
  assign f_ack     = (item_i.seg_flags & FL_ACK) != 8'h00;

  // receive adder: seq + 1, seq + plen + 1 or seq + plen
  assign add_plen = (state_r == CS_ESTABLISHED);
  assign add_one  = (state_r != CS_ESTABLISHED) || f_fin;
  assign rcv_inc  = (add_plen ? {1'b0, plen} : 17'd0) + {16'b0, add_one};
  assign rcv_sum  = item_i.seg_seq + {15'b0, rcv_inc};

  // send adder operands
  always_comb begin
    snd_base = snd_next_r;
    snd_inc  = 16'd1;
    case (item_i.action)
      ACT_CONNECT: snd_base = item_i.initial_seq;
      ACT_RETX:    snd_base = snd_una_r;
      ACT_SEND:    snd_inc  = item_i.send_length;
      default:     snd_base = snd_next_r;
    endcase
  end
  assign snd_sum = snd_base + {16'b0, snd_inc};

  // outcome of the item
  always_comb begin
    state_nxt      = state_r;
    snd_next_nxt   = snd_next_r;
    snd_una_nxt    = snd_una_r;
    rcv_next_nxt   = rcv_next_r;
    snd_wnd_nxt    = snd_wnd_r;
    dec.emit       = 1'b0;
    dec.flags      = FL_ACK;
    dec.seq        = snd_next_r;
    dec.status     = STS_OK;
    dec.start_send = 1'b0;
    case (item_i.action)
      ACT_CONNECT: begin
        if (state_r != CS_CLOSED) begin
          dec.status = STS_INVALID;
        end else begin
          dec.emit     = 1'b1;
          dec.flags    = FL_SYN;
          dec.seq      = item_i.initial_seq;
          snd_una_nxt  = item_i.initial_seq;
          snd_next_nxt = snd_sum;
          state_nxt    = CS_SYN_SENT;
        end
      end
      ACT_RETX: begin
        if (state_r != CS_SYN_SENT) begin
          dec.status = STS_INVALID;
        end else begin
          dec.emit     = 1'b1;
          dec.flags    = FL_SYN;
          dec.seq      = snd_una_r;
          snd_next_nxt = snd_sum;
        end
      end
      ACT_SEND: begin
        if (state_r != CS_ESTABLISHED) begin
          dec.status = STS_INVALID;
        end else if (!tx_en) begin
          // nothing goes out, sequence space is used all the same
          snd_next_nxt = snd_sum;
        end else begin
          dec.start_send = (item_i.send_length != 16'd0);
        end
      end
      ACT_SEGMENT: begin
        if (malformed) begin
          dec.status = STS_PROTO;
        end else if (f_rst) begin
          state_nxt  = CS_CLOSED;
          dec.status = STS_RESET;
        end else begin
          case (state_r)
            CS_SYN_SENT: begin
              if (f_syn && f_ack) begin
                if (item_i.seg_ack != snd_next_r) begin
                  dec.status = STS_PROTO;
                end else begin
                  rcv_next_nxt = rcv_sum;
                  snd_una_nxt  = item_i.seg_ack;
                  snd_wnd_nxt  = item_i.seg_window;
                  dec.emit     = 1'b1;
                  state_nxt    = CS_ESTABLISHED;
                end
              end
            end
            CS_ESTABLISHED: begin
              if (f_fin) begin
                rcv_next_nxt = rcv_sum;
                dec.emit     = 1'b1;
                state_nxt    = CS_CLOSE_WAIT;
              end else if (f_ack) begin
                if (item_i.seg_ack > snd_una_r) begin
                  snd_una_nxt = item_i.seg_ack;
                end
                snd_wnd_nxt = item_i.seg_window;
                if (plen != 16'd0) begin
                  rcv_next_nxt = rcv_sum;
                  dec.emit     = 1'b1;
                end
              end
            end
            CS_FIN_WAIT1: begin
              if (f_fin && f_ack) begin
                rcv_next_nxt = rcv_sum;
                snd_una_nxt  = item_i.seg_ack;
                dec.emit     = 1'b1;
                state_nxt    = CS_TIME_WAIT;
              end else if (f_ack) begin
                snd_una_nxt = item_i.seg_ack;
                state_nxt   = CS_FIN_WAIT2;
              end else if (f_fin) begin
                rcv_next_nxt = rcv_sum;
                dec.emit     = 1'b1;
                state_nxt    = CS_TIME_WAIT;
              end
            end
            CS_FIN_WAIT2: begin
              if (f_fin) begin
                rcv_next_nxt = rcv_sum;
                dec.emit     = 1'b1;
                state_nxt    = CS_TIME_WAIT;
              end
            end
            CS_LAST_ACK: begin
              if (f_ack) begin
                snd_una_nxt = item_i.seg_ack;
                state_nxt   = CS_CLOSED;
              end
            end
            CS_TIME_WAIT: state_nxt = CS_CLOSED;
            default:      state_nxt = state_r;
          endcase
        end
      end
      ACT_CLOSE: begin
        if ((state_r == CS_ESTABLISHED) || (state_r == CS_CLOSE_WAIT)) begin
          dec.emit     = 1'b1;
          dec.flags    = FL_FIN | FL_ACK;
          snd_next_nxt = snd_sum;
          state_nxt    = (state_r == CS_ESTABLISHED) ? CS_FIN_WAIT1 : CS_LAST_ACK;
        end else begin
          dec.status = STS_INVALID;
        end
      end
      default: dec.status = STS_INVALID;
    endcase
    dec.state_nxt = state_nxt;
    dec.ack_nxt   = rcv_next_nxt;
    dec.wnd_nxt   = snd_wnd_nxt;
  end

  // connection registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CS_CLOSED;
      snd_next_r <= '0;
      snd_una_r  <= '0;
      rcv_next_r <= '0;
      snd_wnd_r  <= 16'hFFFF;
    end else if (exec_en) begin
      state_r    <= state_nxt;
      snd_next_r <= snd_next_nxt;
      snd_una_r  <= snd_una_nxt;
      rcv_next_r <= rcv_next_nxt;
      snd_wnd_r  <= snd_wnd_nxt;
    end else if (chunk_en) begin
      snd_next_r <= snd_next_r + {18'b0, chunk_len};
    end
  end

  assign view.state   = state_r;
  assign view.snd_nxt = snd_next_r;
  assign view.rcv_nxt = rcv_next_r;
  assign view.wnd     = snd_wnd_r;

endmodule

`default_nettype wire

// File: rtl/tcf_chunker.sv
// ----------------------------------------------------------------------------
// TCP client connection engine - send chunker
// Shared subtract/compare unit that cuts a send into MSS chunks, one a cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_chunker
  import tcf_pkg::*;
#(
  parameter int MAX_SEG_PAYLOAD = MSS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [LEN_W-1:0] start_len,
  input  wire logic             step,
  output chunk_t                chk
);

  localparam logic [LEN_W-1:0] MSS = LEN_W'(MAX_SEG_PAYLOAD);

  logic             busy_r, busy_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] off_r, off_nxt;
  logic             more;
  logic [LEN_W-1:0] cut;

  // one compare and one subtract per chunk
  assign more = rem_r > MSS;
  assign cut  = more ? MSS : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    off_nxt  = off_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = start_len;
      off_nxt  = '0;
    end else if (step && busy_r) begin
      busy_nxt = more;
      rem_nxt  = rem_r - cut;
      off_nxt  = off_r + cut;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // remaining count and offset are payload
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    off_r <= off_nxt;
  end

  assign chk.busy = busy_r;
  assign chk.last = !more;
  assign chk.off  = off_r;
  assign chk.len  = cut[CHUNK_W-1:0];

endmodule

`default_nettype wire

// File: rtl/tcp_client_connection_fsm.sv
// An item is taken when the engine is idle, and no further item is taken
// until the engine is idle again. Connect, retransmit, close, a received
// segment and any rejected action pass from the accept in SEQ_IDLE to the
// decision in SEQ_EXEC, which updates the connection registers and loads
// the single result word. A send of N bytes while established with
// transmit enabled then moves to SEQ_CHUNK, where the chunker issues one
// segment word per cycle through its shared subtract and compare unit
// while the result register is free, until the last chunk. A send of
// zero bytes, or with transmit disabled, returns to idle after the
// decision. A decision or chunk step waits while the result register
// is still held by out_stall. Configuration writes are always taken
// and must only be made while the engine is idle.
// ----------------------------------------------------------------------------
// TCP client connection engine - top level
// Item sequencer, configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tcp_client_connection_fsm_macros.svh"

module tcp_client_connection_fsm
  import tcf_pkg::*;
#(
  parameter int MAX_SEG_PAYLOAD = MSS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  // item input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_action,
  input  wire logic [SEQ_W-1:0]     in_initial_seq,
  input  wire logic [LEN_W-1:0]     in_send_length,
  input  wire logic [7:0]           in_seg_flags,
  input  wire logic [SEQ_W-1:0]     in_seg_seq,
  input  wire logic [SEQ_W-1:0]     in_seg_ack,
  input  wire logic [WIN_W-1:0]     in_seg_window,
  input  wire logic [3:0]           in_seg_data_offset,
  input  wire logic [LEN_W-1:0]     in_seg_length,

  // result output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_has_segment,
  output logic [7:0]                out_flags,
  output logic [SEQ_W-1:0]          out_seq,
  output logic [SEQ_W-1:0]          out_ack,
  output logic [WIN_W-1:0]          out_window,
  output logic [LEN_W-1:0]          out_chunk_offset,
  output logic [CHUNK_W-1:0]        out_chunk_length,
  output logic [1:0]                out_status,
  output logic [2:0]                out_conn_state,
  output logic [WIN_W-1:0]          out_peer_window,
  output logic                      out_last,

  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIN_W-1:0]     cfg_wdata
);

  seq_state_t       seq_state_r, seq_state_nxt;
  item_t            item_r;
  logic             tx_en_r;
  logic [WIN_W-1:0] rcv_wnd_r;
  result_t          res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_take;
  logic             out_free;
  logic             exec_go;
  logic             chunk_step;
  logic             res_load;
  conn_dec_t        dec;
  conn_view_t       view;
  chunk_t           chk;

  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign exec_go    = (seq_state_r == SEQ_EXEC) && out_free;
  assign chunk_step = (seq_state_r == SEQ_CHUNK) && out_free;
  assign res_load   = (exec_go && !dec.start_send) || chunk_step;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_en_r   <= 1'b1;
      rcv_wnd_r <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TX_ENABLED:  tx_en_r   <= cfg_wdata[0];
        REG_RECV_WINDOW: rcv_wnd_r <= cfg_wdata;
        default:         tx_en_r   <= tx_en_r;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action          <= in_action;
      item_r.initial_seq     <= in_initial_seq;
      item_r.send_length     <= in_send_length;
      item_r.seg_flags       <= in_seg_flags;
      item_r.seg_seq         <= in_seg_seq;
      item_r.seg_ack         <= in_seg_ack;
      item_r.seg_window      <= in_seg_window;
      item_r.seg_data_offset <= in_seg_data_offset;
      item_r.seg_length      <= in_seg_length;
    end
  end

  tcf_conn u_conn (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_i    (item_r),
    .tx_en     (tx_en_r),
    .exec_en   (exec_go),
    .chunk_en  (chunk_step),
    .chunk_len (chk.len),
    .dec       (dec),
    .view      (view)
  );

  tcf_chunker #(
    .MAX_SEG_PAYLOAD (MAX_SEG_PAYLOAD)
  ) u_chunker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (exec_go && dec.start_send),
    .start_len (item_r.send_length),
    .step      (chunk_step),
    .chk       (chk)
  );

  // sequencer
  always_comb begin
    seq_state_nxt = seq_state_r;
    case (seq_state_r)
      SEQ_IDLE: begin
        if (in_take) seq_state_nxt = SEQ_EXEC;
      end
      SEQ_EXEC: begin
        if (exec_go) seq_state_nxt = dec.start_send ? SEQ_CHUNK : SEQ_IDLE;
      end
      SEQ_CHUNK: begin
        if (chunk_step && chk.last) seq_state_nxt = SEQ_IDLE;
      end
      default: seq_state_nxt = SEQ_IDLE;
    endcase
  end

  assign in_stall = (seq_state_r != SEQ_IDLE);

  // result word
  always_comb begin
    res_nxt = res_r;
    if (chunk_step) begin
      res_nxt.has_segment  = 1'b1;
      res_nxt.flags        = chk.last ? (FL_ACK | FL_PSH) : FL_ACK;
      res_nxt.seq          = view.snd_nxt;
      res_nxt.ack          = view.rcv_nxt;
      res_nxt.window       = rcv_wnd_r;
      res_nxt.chunk_offset = chk.off;
      res_nxt.chunk_length = chk.len;
      res_nxt.status       = STS_OK;
      res_nxt.conn_state   = view.state;
      res_nxt.peer_window  = view.wnd;
      res_nxt.last         = chk.last;
    end else if (exec_go) begin
      res_nxt.has_segment  = dec.emit && tx_en_r;
      res_nxt.flags        = res_nxt.has_segment ? dec.flags : 8'h00;
      res_nxt.seq          = res_nxt.has_segment ? dec.seq : '0;
      res_nxt.ack          = res_nxt.has_segment ? dec.ack_nxt : '0;
      res_nxt.window       = res_nxt.has_segment ? rcv_wnd_r : '0;
      res_nxt.chunk_offset = '0;
      res_nxt.chunk_length = '0;
      res_nxt.status       = dec.status;
      res_nxt.conn_state   = dec.state_nxt;
      res_nxt.peer_window  = dec.wnd_nxt;
      res_nxt.last         = 1'b1;
    end
  end

  assign out_valid_nxt = res_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r <= SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      seq_state_r <= seq_state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_segment  = res_r.has_segment;
  assign out_flags        = res_r.flags;
  assign out_seq          = res_r.seq;
  assign out_ack          = res_r.ack;
  assign out_window       = res_r.window;
  assign out_chunk_offset = res_r.chunk_offset;
  assign out_chunk_length = res_r.chunk_length;
  assign out_status       = res_r.status;
  assign out_conn_state   = res_r.conn_state;
  assign out_peer_window  = res_r.peer_window;
  assign out_last         = res_r.last;

  // checks
  `TCF_ASSERT_NXT(a_take_exec, clk, rst_n, in_take, seq_state_r == SEQ_EXEC, "item not decoded")
  `TCF_ASSERT_NXT(a_send_busy, clk, rst_n, exec_go && dec.start_send, chk.busy, "chunker idle")
  `TCF_ASSERT_IMP(a_chunk_busy, clk, rst_n, seq_state_r == SEQ_CHUNK, chk.busy, "chunk lost")

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP client connection engine - testbench
// Runs connection actions through the engine: closed-state rejects, the
// opening handshake, chunked sends, teardown and peer resets, then random
// connection lifecycles with noise. Every result word is checked field by
// field against a connection model kept alongside. Register settings,
// sender gaps and receiver stalls change between phases.
// ----------------------------------------------------------------------------
module testbench;
  import tcf_pkg::*;

  localparam int SEG_MAX        = MSS_DEFAULT;
  localparam int WORDS_PER_STEP = 64;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 8;

  // action codes the engine does not define
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  // register indexes past the defined ones
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  // flag bits the engine never looks at
  localparam logic [7:0] FL_UPPER = 8'hE0;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid           = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_action          = '0;
  logic [SEQ_W-1:0]     in_initial_seq     = '0;
  logic [LEN_W-1:0]     in_send_length     = '0;
  logic [7:0]           in_seg_flags       = '0;
  logic [SEQ_W-1:0]     in_seg_seq         = '0;
  logic [SEQ_W-1:0]     in_seg_ack         = '0;
  logic [WIN_W-1:0]     in_seg_window      = '0;
  logic [3:0]           in_seg_data_offset = '0;
  logic [LEN_W-1:0]     in_seg_length      = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_has_segment;
  logic [7:0]           out_flags;
  logic [SEQ_W-1:0]     out_seq;
  logic [SEQ_W-1:0]     out_ack;
  logic [WIN_W-1:0]     out_window;
  logic [LEN_W-1:0]     out_chunk_offset;
  logic [CHUNK_W-1:0]   out_chunk_length;
  logic [1:0]           out_status;
  logic [2:0]           out_conn_state;
  logic [WIN_W-1:0]     out_peer_window;
  logic                 out_last;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIN_W-1:0]     cfg_wdata = '0;

  tcp_client_connection_fsm #(
    .MAX_SEG_PAYLOAD (SEG_MAX)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_initial_seq     (in_initial_seq),
    .in_send_length     (in_send_length),
    .in_seg_flags       (in_seg_flags),
    .in_seg_seq         (in_seg_seq),
    .in_seg_ack         (in_seg_ack),
    .in_seg_window      (in_seg_window),
    .in_seg_data_offset (in_seg_data_offset),
    .in_seg_length      (in_seg_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_has_segment    (out_has_segment),
    .out_flags          (out_flags),
    .out_seq            (out_seq),
    .out_ack            (out_ack),
    .out_window         (out_window),
    .out_chunk_offset   (out_chunk_offset),
    .out_chunk_length   (out_chunk_length),
    .out_status         (out_status),
    .out_conn_state     (out_conn_state),
    .out_peer_window    (out_peer_window),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // connection model: registers, live connection state, words still due
  logic        exp_tx_en    = 1'b1;
  logic [15:0] exp_adv_wnd  = 16'hFFFF;
  conn_state_t exp_state    = CS_CLOSED;
  logic [31:0] exp_snd_nxt  = '0;
  logic [31:0] exp_snd_una  = '0;
  logic [31:0] exp_rcv_nxt  = '0;
  logic [15:0] exp_peer_wnd = 16'hFFFF;
  result_t     step_words[$];
  result_t     awaited_words[$];

  int errors      = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_len    = 0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  bit offering    = 1'b0;

  // queue one segment word for the current step, unless transmit is off
  function automatic void add_seg(input logic [7:0] fl, input logic [31:0] sq,
                                  input logic [15:0] off, input logic [13:0] len);
    result_t w;
    w = '0;
    if (exp_tx_en && step_words.size() < WORDS_PER_STEP) begin
      w.has_segment  = 1'b1;
      w.flags        = fl;
      w.seq          = sq;
      w.ack          = exp_rcv_nxt;
      w.window       = exp_adv_wnd;
      w.chunk_offset = off;
      w.chunk_length = len;
      step_words.push_back(w);
    end
  endfunction

  // advance the connection by one item and queue the words it produces
  task automatic advance_connection(input item_t it);
    logic [1:0] sts;
    logic [7:0] fl;
    int         hlen;
    int         slen;
    int         plen;
    int         off;
    int         chunk;
    result_t    w;
    step_words.delete();
    sts = STS_OK;
    case (it.action)
      ACT_CONNECT: begin
        if (exp_state != CS_CLOSED) begin
          sts = STS_INVALID;
        end else begin
          exp_snd_nxt = it.initial_seq;
          exp_snd_una = it.initial_seq;
          add_seg(FL_SYN, exp_snd_nxt, '0, '0);
          exp_snd_nxt = exp_snd_nxt + 32'd1;
          exp_state   = CS_SYN_SENT;
        end
      end
      ACT_RETX: begin
        if (exp_state != CS_SYN_SENT) begin
          sts = STS_INVALID;
        end else begin
          add_seg(FL_SYN, exp_snd_una, '0, '0);
          exp_snd_nxt = exp_snd_una + 32'd1;
        end
      end
      ACT_SEND: begin
        if (exp_state != CS_ESTABLISHED) begin
          sts = STS_INVALID;
        end else begin
          // cut into MSS chunks, PSH on the final one
          off = 0;
          while (off < int'(it.send_length)) begin
            chunk = int'(it.send_length) - off;
            if (chunk > SEG_MAX) chunk = SEG_MAX;
            fl = FL_ACK;
            if (off + chunk >= int'(it.send_length)) fl = fl | FL_PSH;
            add_seg(fl, exp_snd_nxt, 16'(off), 14'(chunk));
            exp_snd_nxt = exp_snd_nxt + 32'(chunk);
            off = off + chunk;
          end
        end
      end
      ACT_SEGMENT: begin
        hlen = int'(it.seg_data_offset) * 4;
        slen = int'(it.seg_length);
        if (slen < int'(HDR_BYTES) || hlen < int'(HDR_BYTES) || hlen > slen) begin
          sts = STS_PROTO;
        end else if ((it.seg_flags & FL_RST) != 0) begin
          exp_state = CS_CLOSED;
          sts = STS_RESET;
        end else begin
          plen = slen - hlen;
          case (exp_state)
            CS_SYN_SENT: begin
              if ((it.seg_flags & (FL_SYN | FL_ACK)) == (FL_SYN | FL_ACK)) begin
                if (it.seg_ack != exp_snd_nxt) begin
                  sts = STS_PROTO;
                end else begin
                  exp_rcv_nxt  = it.seg_seq + 32'd1;
                  exp_snd_una  = it.seg_ack;
                  exp_peer_wnd = it.seg_window;
                  add_seg(FL_ACK, exp_snd_nxt, '0, '0);
                  exp_state = CS_ESTABLISHED;
                end
              end
            end
            CS_ESTABLISHED: begin
              if ((it.seg_flags & FL_FIN) != 0) begin
                exp_rcv_nxt = it.seg_seq + 32'(plen) + 32'd1;
                add_seg(FL_ACK, exp_snd_nxt, '0, '0);
                exp_state = CS_CLOSE_WAIT;
              end else if ((it.seg_flags & FL_ACK) != 0) begin
                if (it.seg_ack > exp_snd_una) exp_snd_una = it.seg_ack;
                exp_peer_wnd = it.seg_window;
                if (plen > 0) begin
                  exp_rcv_nxt = it.seg_seq + 32'(plen);
                  add_seg(FL_ACK, exp_snd_nxt, '0, '0);
                end
              end
            end
            CS_FIN_WAIT1: begin
              if ((it.seg_flags & (FL_FIN | FL_ACK)) == (FL_FIN | FL_ACK)) begin
                exp_rcv_nxt = it.seg_seq + 32'd1;
                exp_snd_una = it.seg_ack;
                add_seg(FL_ACK, exp_snd_nxt, '0, '0);
                exp_state = CS_TIME_WAIT;
              end else if ((it.seg_flags & FL_ACK) != 0) begin
                exp_snd_una = it.seg_ack;
                exp_state = CS_FIN_WAIT2;
              end else if ((it.seg_flags & FL_FIN) != 0) begin
                exp_rcv_nxt = it.seg_seq + 32'd1;
                add_seg(FL_ACK, exp_snd_nxt, '0, '0);
                exp_state = CS_TIME_WAIT;
              end
            end
            CS_FIN_WAIT2: begin
              if ((it.seg_flags & FL_FIN) != 0) begin
                exp_rcv_nxt = it.seg_seq + 32'd1;
                add_seg(FL_ACK, exp_snd_nxt, '0, '0);
                exp_state = CS_TIME_WAIT;
              end
            end
            CS_LAST_ACK: begin
              if ((it.seg_flags & FL_ACK) != 0) begin
                exp_snd_una = it.seg_ack;
                exp_state = CS_CLOSED;
              end
            end
            CS_TIME_WAIT: exp_state = CS_CLOSED;
            default: ;
          endcase
        end
      end
      ACT_CLOSE: begin
        if (exp_state == CS_ESTABLISHED || exp_state == CS_CLOSE_WAIT) begin
          add_seg(FL_FIN | FL_ACK, exp_snd_nxt, '0, '0);
          exp_snd_nxt = exp_snd_nxt + 32'd1;
          exp_state = (exp_state == CS_ESTABLISHED) ? CS_FIN_WAIT1 : CS_LAST_ACK;
        end else begin
          sts = STS_INVALID;
        end
      end
      default: sts = STS_INVALID;
    endcase

    // a step with no segment still yields one status word
    if (step_words.size() == 0) begin
      w = '0;
      step_words.push_back(w);
    end
    foreach (step_words[i]) begin
      w = step_words[i];
      w.status      = sts;
      w.conn_state  = exp_state;
      w.peer_window = exp_peer_wnd;
      w.last        = (i == step_words.size() - 1);
      awaited_words.push_back(w);
    end
  endtask

  // item with the given action and every other field random
  function automatic item_t act_item(input logic [2:0] act);
    item_t it;
    it.action          = act;
    it.initial_seq     = $urandom;
    it.send_length     = 16'($urandom);
    it.seg_flags       = 8'($urandom);
    it.seg_seq         = $urandom;
    it.seg_ack         = $urandom;
    it.seg_window      = 16'($urandom);
    it.seg_data_offset = 4'($urandom);
    it.seg_length      = 16'($urandom);
    return it;
  endfunction

  // well-formed received segment carrying plen payload bytes
  function automatic item_t seg_item(input logic [7:0] fl, input logic [31:0] sq,
                                     input logic [31:0] ak, input int plen);
    item_t it;
    it = act_item(ACT_SEGMENT);
    it.seg_flags       = fl;
    it.seg_seq         = sq;
    it.seg_ack         = ak;
    it.seg_data_offset = 4'($urandom_range(15, 5));
    it.seg_length      = 16'(int'(it.seg_data_offset) * 4 + plen);
    return it;
  endfunction

  // next random item: mostly a plausible move for the current state
  function automatic item_t next_item();
    item_t      it;
    int         pick;
    logic [7:0] extra;
    pick  = $urandom_range(99);
    extra = 8'($urandom) & (FL_PSH | FL_UPPER);
    it    = act_item(3'($urandom_range(7)));
    if (pick < 8) return it;
    // malformed segments: short, short header, header past the end
    if (pick < 12) begin
      it.action = ACT_SEGMENT;
      if (pick < 9) begin
        it.seg_length = 16'($urandom_range(19));
      end else if (pick < 11) begin
        it.seg_data_offset = 4'($urandom_range(4));
      end else begin
        it.seg_data_offset = 4'($urandom_range(15, 6));
        it.seg_length = 16'($urandom_range(int'(it.seg_data_offset) * 4 - 1, 20));
      end
      return it;
    end
    pick = $urandom_range(99);
    case (exp_state)
      CS_CLOSED: begin
        if (pick < 85) begin
          it.action = ACT_CONNECT;
          if (pick < 15) it.initial_seq = 32'hFFFF_FFFF - 32'($urandom_range(3));
        end else begin
          it = seg_item(FL_ACK | extra, $urandom, $urandom, $urandom_range(40));
        end
      end
      CS_SYN_SENT: begin
        if (pick < 20) it.action = ACT_RETX;
        else if (pick < 85) it = seg_item(FL_SYN | FL_ACK | extra, $urandom, exp_snd_nxt, 0);
        else if (pick < 93)
          it = seg_item(FL_SYN | FL_ACK, $urandom, exp_snd_nxt + 32'($urandom_range(9, 1)), 0);
        else it = seg_item(FL_RST | extra, $urandom, $urandom, 0);
      end
      CS_ESTABLISHED: begin
        if (pick < 35) begin
          it.action = ACT_SEND;
          pick = $urandom_range(99);
          if (pick < 3) it.send_length = 16'($urandom_range(65535, 30000));
          else if (pick < 10) it.send_length = '0;
          else it.send_length = 16'($urandom_range(3000, 1));
        end else if (pick < 75) begin
          it = seg_item(FL_ACK | extra, exp_rcv_nxt, exp_snd_nxt - 32'($urandom_range(3000)),
                        ($urandom_range(3) == 0) ? 0 : $urandom_range(1460));
        end else if (pick < 83) begin
          it = seg_item(FL_FIN | FL_ACK | extra, exp_rcv_nxt, exp_snd_nxt, $urandom_range(200));
        end else if (pick < 93) begin
          it.action = ACT_CLOSE;
        end else if (pick < 96) begin
          it = seg_item(FL_RST | extra, $urandom, $urandom, 0);
        end else begin
          it = seg_item(extra, $urandom, $urandom, $urandom_range(100));
        end
      end
      CS_FIN_WAIT1: begin
        if (pick < 40) it = seg_item(FL_ACK | extra, exp_rcv_nxt, exp_snd_nxt, 0);
        else if (pick < 70) it = seg_item(FL_FIN | FL_ACK | extra, exp_rcv_nxt, exp_snd_nxt, 0);
        else if (pick < 90) it = seg_item(FL_FIN | extra, exp_rcv_nxt, $urandom, 0);
        else it = seg_item(extra, $urandom, $urandom, $urandom_range(100));
      end
      CS_FIN_WAIT2: begin
        if (pick < 75) it = seg_item(FL_FIN | extra, exp_rcv_nxt, exp_snd_nxt, 0);
        else it = seg_item(FL_ACK | extra, exp_rcv_nxt, exp_snd_nxt, 0);
      end
      CS_TIME_WAIT: begin
        it = seg_item(8'($urandom) & ~FL_RST, $urandom, $urandom, $urandom_range(100));
      end
      CS_CLOSE_WAIT: begin
        if (pick < 60) it.action = ACT_CLOSE;
        else if (pick < 80) it = seg_item(FL_ACK | extra, $urandom, $urandom, $urandom_range(100));
        else it.action = ACT_SEND;
      end
      CS_LAST_ACK: begin
        if (pick < 80) it = seg_item(FL_ACK | extra, exp_rcv_nxt, exp_snd_nxt, 0);
        else it = seg_item(extra, $urandom, $urandom, 0);
      end
      default: ;
    endcase
    return it;
  endfunction

  // offer one word, hold it until taken, then maybe leave a gap
  task automatic send_word(input item_t it);
    int gap;
    gap = 0;
    in_valid           <= 1'b1;
    in_action          <= it.action;
    in_initial_seq     <= it.initial_seq;
    in_send_length     <= it.send_length;
    in_seg_flags       <= it.seg_flags;
    in_seg_seq         <= it.seg_seq;
    in_seg_ack         <= it.seg_ack;
    in_seg_window      <= it.seg_window;
    in_seg_data_offset <= it.seg_data_offset;
    in_seg_length      <= it.seg_length;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_connection(it);
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid if still raised, then wait for every due word
  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TX_ENABLED) exp_tx_en = data[0];
    else if (idx == REG_RECV_WINDOW) exp_adv_wnd = data;
  endtask

  // write both registers with the engine idle, optionally the spare indexes too
  task automatic set_regs(input logic [15:0] tx_word, input logic [15:0] wnd, input bit spare);
    wait_drained();
    write_reg(REG_TX_ENABLED, tx_word);
    write_reg(REG_RECV_WINDOW, wnd);
    if (spare) begin
      write_reg(REG_SPARE_LO, 16'($urandom));
      write_reg(REG_SPARE_HI, 16'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver: long hold-offs on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // compare each accepted result word with the oldest one due
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got seq %h flags %h",
                 $time, out_seq, out_flags);
        errors++;
      end else begin
        want = awaited_words.pop_front();
        check_field("has_segment", 32'(want.has_segment), 32'(out_has_segment));
        check_field("flags", 32'(want.flags), 32'(out_flags));
        check_field("seq", want.seq, out_seq);
        check_field("ack", want.ack, out_ack);
        check_field("window", 32'(want.window), 32'(out_window));
        check_field("chunk_offset", 32'(want.chunk_offset), 32'(out_chunk_offset));
        check_field("chunk_length", 32'(want.chunk_length), 32'(out_chunk_length));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("conn_state", 32'(want.conn_state), 32'(out_conn_state));
        check_field("peer_window", 32'(want.peer_window), 32'(out_peer_window));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // every action except connect is refused while closed; segments ignored
  task automatic test_closed_rejects();
    send_word(seg_item(FL_ACK, $urandom, $urandom, 0));
    send_word(act_item(ACT_RETX));
    send_word(act_item(ACT_SEND));
    send_word(act_item(ACT_CLOSE));
    send_word(act_item(ACT_UNUSED_LO));
    send_word(act_item(ACT_UNUSED_HI));
  endtask

  // connect with a wrapping ISN, retransmit, bad and malformed replies, then SYN+ACK
  task automatic test_handshake();
    item_t it;
    it = act_item(ACT_CONNECT);
    it.initial_seq = 32'hFFFF_FFFF;
    send_word(it);
    send_word(act_item(ACT_CONNECT));
    send_word(act_item(ACT_RETX));
    send_word(seg_item(FL_SYN | FL_ACK, $urandom, exp_snd_nxt + 32'd1, 0));
    it = seg_item(FL_SYN | FL_ACK, $urandom, exp_snd_nxt, 0);
    it.seg_length = 16'd19;
    send_word(it);
    it = seg_item(FL_SYN | FL_ACK, $urandom, exp_snd_nxt, 0);
    it.seg_data_offset = 4'd4;
    it.seg_length = 16'd100;
    send_word(it);
    it = seg_item(FL_SYN | FL_ACK, $urandom, exp_snd_nxt, 0);
    it.seg_data_offset = 4'd15;
    it.seg_length = 16'd59;
    send_word(it);
    it = seg_item(FL_SYN | FL_ACK, 32'hFFFF_FFFF, exp_snd_nxt, 0);
    it.seg_window = '0;
    send_word(it);
  endtask

  // empty, largest and just-over-MSS sends, then inbound data and a pure ack
  task automatic test_bulk_send();
    item_t it;
    it = act_item(ACT_SEND);
    it.send_length = '0;
    send_word(it);
    it.send_length = 16'hFFFF;
    send_word(it);
    it.send_length = 16'(SEG_MAX + 1);
    send_word(it);
    it = seg_item(FL_ACK | FL_PSH, exp_rcv_nxt, exp_snd_nxt, SEG_MAX);
    it.seg_window = 16'hFFFF;
    send_word(it);
    send_word(seg_item(FL_ACK, exp_rcv_nxt, 32'hFFFF_FFFF, 0));
  endtask

  // active close down to closed through time wait
  task automatic test_teardown();
    send_word(act_item(ACT_CLOSE));
    send_word(seg_item(FL_ACK, exp_rcv_nxt, exp_snd_nxt, 0));
    send_word(seg_item(FL_FIN, exp_rcv_nxt, exp_snd_nxt, 0));
    send_word(seg_item(~FL_RST, $urandom, $urandom, 0));
  endtask

  // reopen, then an all-flags segment at the largest sizes resets it
  task automatic test_peer_reset();
    item_t it;
    send_word(act_item(ACT_CONNECT));
    send_word(seg_item(FL_SYN | FL_ACK, $urandom, exp_snd_nxt, 0));
    it = act_item(ACT_SEGMENT);
    it.seg_flags       = '1;
    it.seg_data_offset = '1;
    it.seg_length      = '1;
    send_word(it);
  endtask

  task automatic test_random_traffic(input int count, input int idle, input int stall);
    int k;
    idle_pct  = idle;
    stall_pct = stall;
    for (k = 0; k < count; k++) send_word(next_item());
  endtask

  // long receiver hold-off while words keep coming, then a full drain
  task automatic test_backpressure();
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    hold_len  = 300;
    hold_req++;
    for (k = 0; k < 20; k++) send_word(next_item());
    wait_drained();
    for (k = 0; k < 10; k++) send_word(next_item());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_closed_rejects();
    test_handshake();
    test_bulk_send();
    test_teardown();
    test_peer_reset();
    set_regs(16'h0000, 16'h0000, 1'b1);
    test_random_traffic(60, 0, 0);
    set_regs(16'hFFFF, 16'hFFFF, 1'b0);
    test_random_traffic(80, 56, 0);
    set_regs(16'h0001 | 16'($urandom), 16'($urandom), 1'b1);
    test_random_traffic(80, 0, 56);
    test_backpressure();
    set_regs(16'hFFFE, 16'($urandom), 1'b0);
    test_random_traffic(40, 10, 10);
    set_regs(16'h0001, 16'h0000, 1'b0);
    test_random_traffic(60, 10, 10);
    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
